// ===== rtl/pgca_pkg.sv =====
// pgca_pkg: shared types and fixed field widths for the polygon convexity and area core
// no dependencies; used by the channel interfaces and every rtl module
package pgca_pkg;

  localparam int COORD_W = 16;
  localparam int AREA_W  = 47;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 48;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [SUM_W-1:0]          sum_t;

  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_sign_t;

  // where a vertex sits in its polygon, carried down the pipeline
  typedef struct packed {
    logic has_prev;
    logic first_turn;
    logic test_turn;
    logic last;
  } stage_flags_t;

endpackage

// ===== rtl/pgca_if.sv =====
// pgca_if: valid/ready channel interfaces for vertices in and results out
// depends on pgca_pkg
interface pgca_vertex_if import pgca_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  logic   last_vertex;

  modport source (output valid, output x_coord, output y_coord, output last_vertex,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input last_vertex,
                output ready);
endinterface

interface pgca_result_if import pgca_pkg::*; ();
  logic   valid;
  logic   ready;
  area_t  area_twice;
  logic   is_convex;
  count_t vertex_count;

  modport source (output valid, output area_twice, output is_convex, output vertex_count,
                  input ready);
  modport sink (input valid, input area_twice, input is_convex, input vertex_count,
                output ready);
endinterface

// ===== rtl/pgca_mult.sv =====
// pgca_mult: edge differences and the six registered products per vertex
// (turn cross product, link shoelace term, closing shoelace term); uses pgca_pkg
module pgca_mult import pgca_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [CW-1:0]       cur_x,
  input  logic signed [CW-1:0]       cur_y,
  input  logic signed [CW-1:0]       prev_x,
  input  logic signed [CW-1:0]       prev_y,
  input  logic signed [CW-1:0]       prev2_x,
  input  logic signed [CW-1:0]       prev2_y,
  input  logic signed [CW-1:0]       first_x,
  input  logic signed [CW-1:0]       first_y,
  output logic signed [2*CW+1:0]     turn_a_r,
  output logic signed [2*CW+1:0]     turn_b_r,
  output logic signed [2*CW-1:0]     link_a_r,
  output logic signed [2*CW-1:0]     link_b_r,
  output logic signed [2*CW-1:0]     close_a_r,
  output logic signed [2*CW-1:0]     close_b_r
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int QW = 2 * CW;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [PW-1:0] turn_a_nxt, turn_b_nxt;
  logic signed [QW-1:0] link_a_nxt, link_b_nxt, close_a_nxt, close_b_nxt;

  always_comb begin
    d1x = DW'(prev_x) - DW'(prev2_x);
    d1y = DW'(prev_y) - DW'(prev2_y);
    d2x = DW'(cur_x) - DW'(prev_x);
    d2y = DW'(cur_y) - DW'(prev_y);
    turn_a_nxt  = d1x * d2y;
    turn_b_nxt  = d1y * d2x;
    link_a_nxt  = prev_x * cur_y;
    link_b_nxt  = cur_x * prev_y;
    close_a_nxt = cur_x * first_y;
    close_b_nxt = first_x * cur_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn_a_r  <= turn_a_nxt;
      turn_b_r  <= turn_b_nxt;
      link_a_r  <= link_a_nxt;
      link_b_r  <= link_b_nxt;
      close_a_r <= close_a_nxt;
      close_b_r <= close_b_nxt;
    end
  end

endmodule

// ===== rtl/polygon_convexity_and_area_core.sv =====
// polygon_convexity_and_area_core: streaming shoelace area and convexity test
// depends on pgca_pkg, pgca_if (channel interfaces) and pgca_mult
//
//   channel   dir  transfer when          payload
//   in_vtx    in   valid && ready         x_coord, y_coord, last_vertex
//   out_res   out  valid && ready         area_twice, is_convex, vertex_count
//
// one vertex per cycle while input is not stalled; five stages (capture, multiply, reduce,
// accumulate, magnitude) raise out_res.valid once its last vertex has passed them all
// rst_n is synchronous; it clears stage valids, vertex count and accumulators
// each stage advances when the one below is empty or moving, so a held result stalls
// input only once every stage behind it is full
module polygon_convexity_and_area_core import pgca_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  pgca_vertex_if.sink     in_vtx,
  pgca_result_if.source   out_res
);

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int PW    = 2 * (CW + 1);
  localparam int XW    = PW + 1;
  localparam int QW    = 2 * CW;
  localparam int TW    = QW + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  // stage handshake
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic accept;

  assign en5 = !v5_r || out_res.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_vtx.ready = en1;
  assign accept = in_vtx.valid && en1;

  // coordinate intake: low COORD_BITS bits, sign taken from the top one
  logic [31:0] x_raw32, y_raw32;
  logic signed [CW-1:0] in_x, in_y;

  assign x_raw32 = {{(32-COORD_W){1'b0}}, in_vtx.x_coord};
  assign y_raw32 = {{(32-COORD_W){1'b0}}, in_vtx.y_coord};
  assign in_x = signed'(x_raw32[CW-1:0]);
  assign in_y = signed'(y_raw32[CW-1:0]);

  // vertex history
  logic [CNT_W-1:0]     cnt_r, cnt_inc;
  logic signed [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, prev2_x_r, prev2_y_r;
  logic signed [CW-1:0] first_x_sel, first_y_sel;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign first_x_sel = (cnt_r == '0) ? in_x : first_x_r;
  assign first_y_sel = (cnt_r == '0) ? in_y : first_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= in_vtx.last_vertex ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_x_r <= first_x_sel;
      first_y_r <= first_y_sel;
      prev2_x_r <= prev_x_r;
      prev2_y_r <= prev_y_r;
      prev_x_r  <= in_x;
      prev_y_r  <= in_y;
    end
  end

  // stage 1: captured vertex with its neighbors
  logic signed [CW-1:0] s1_cur_x_r, s1_cur_y_r, s1_prev_x_r, s1_prev_y_r;
  logic signed [CW-1:0] s1_prev2_x_r, s1_prev2_y_r, s1_first_x_r, s1_first_y_r;
  stage_flags_t         s1_flags_r, s2_flags_r, s3_flags_r;
  logic [CNT_W-1:0]     s1_count_r, s2_count_r, s3_count_r, s4_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_vtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_x_r   <= in_x;
      s1_cur_y_r   <= in_y;
      s1_prev_x_r  <= prev_x_r;
      s1_prev_y_r  <= prev_y_r;
      s1_prev2_x_r <= prev2_x_r;
      s1_prev2_y_r <= prev2_y_r;
      s1_first_x_r <= first_x_sel;
      s1_first_y_r <= first_y_sel;
      s1_flags_r.has_prev   <= cnt_r != '0;
      s1_flags_r.first_turn <= cnt_r == CNT_TWO;
      s1_flags_r.test_turn  <= cnt_r > CNT_TWO;
      s1_flags_r.last       <= in_vtx.last_vertex;
      s1_count_r <= cnt_inc;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] turn_a, turn_b;
  logic signed [QW-1:0] link_a, link_b, close_a, close_b;

  pgca_mult #(.CW(CW)) u_mult (
    .clk       (clk),
    .en        (en2),
    .cur_x     (s1_cur_x_r),
    .cur_y     (s1_cur_y_r),
    .prev_x    (s1_prev_x_r),
    .prev_y    (s1_prev_y_r),
    .prev2_x   (s1_prev2_x_r),
    .prev2_y   (s1_prev2_y_r),
    .first_x   (s1_first_x_r),
    .first_y   (s1_first_y_r),
    .turn_a_r  (turn_a),
    .turn_b_r  (turn_b),
    .link_a_r  (link_a),
    .link_b_r  (link_b),
    .close_a_r (close_a),
    .close_b_r (close_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_flags_r <= s1_flags_r;
      s2_count_r <= s1_count_r;
    end
  end

  // stage 3: turn sign and shoelace increment
  logic signed [XW-1:0] cross_prod;
  logic signed [TW-1:0] link_t, close_t;
  logic signed [63:0]   link64, close64;
  turn_sign_t           sign_nxt, s3_sign_r;
  sum_t                 delta_nxt, s3_delta_r;

  always_comb begin
    cross_prod = XW'(turn_a) - XW'(turn_b);
    link_t     = TW'(link_a) - TW'(link_b);
    close_t    = TW'(close_a) - TW'(close_b);
    link64     = 64'(link_t);
    close64    = 64'(close_t);
    if (cross_prod == '0) begin
      sign_nxt = TURN_NONE;
    end else if (cross_prod[XW-1]) begin
      sign_nxt = TURN_NEG;
    end else begin
      sign_nxt = TURN_POS;
    end
    delta_nxt = (s2_flags_r.has_prev ? link64[SUM_W-1:0] : '0)
              + (s2_flags_r.last ? close64[SUM_W-1:0] : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sign_r  <= sign_nxt;
      s3_delta_r <= delta_nxt;
      s3_flags_r <= s2_flags_r;
      s3_count_r <= s2_count_r;
    end
  end

  // stage 4: per-polygon accumulators; only a last vertex moves on
  sum_t       sum_r, sum_nxt, s4_sum_r;
  turn_sign_t first_sign_r, first_sign_nxt;
  logic       convex_r, convex_nxt, s4_convex_r;
  logic       load4;

  assign load4 = en4 && v3_r;

  always_comb begin
    sum_nxt        = sum_r + s3_delta_r;
    first_sign_nxt = first_sign_r;
    convex_nxt     = convex_r;
    if (s3_flags_r.first_turn) begin
      first_sign_nxt = s3_sign_r;
    end else if (s3_flags_r.test_turn && first_sign_r != TURN_NONE &&
                 s3_sign_r != TURN_NONE && s3_sign_r != first_sign_r) begin
      convex_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r         <= 1'b0;
      sum_r        <= '0;
      first_sign_r <= TURN_NONE;
      convex_r     <= 1'b1;
    end else begin
      if (en4) begin
        v4_r <= v3_r && s3_flags_r.last;
      end
      if (load4) begin
        if (s3_flags_r.last) begin
          sum_r        <= '0;
          first_sign_r <= TURN_NONE;
          convex_r     <= 1'b1;
        end else begin
          sum_r        <= sum_nxt;
          first_sign_r <= first_sign_nxt;
          convex_r     <= convex_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load4 && s3_flags_r.last) begin
      s4_sum_r    <= sum_nxt;
      s4_convex_r <= convex_nxt;
      s4_count_r  <= s3_count_r;
    end
  end

  // stage 5: magnitude into the result register
  sum_t        mag;
  logic [31:0] count32;
  area_t       area_r;
  logic        is_convex_r;
  count_t      count_out_r;

  assign mag     = s4_sum_r[SUM_W-1] ? (~s4_sum_r + 1'b1) : s4_sum_r;
  assign count32 = 32'(s4_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      area_r      <= mag[AREA_W-1:0];
      is_convex_r <= s4_convex_r;
      count_out_r <= count32[COUNT_W-1:0];
    end
  end

  assign out_res.valid        = v5_r;
  assign out_res.area_twice   = area_r;
  assign out_res.is_convex    = is_convex_r;
  assign out_res.vertex_count = count_out_r;

endmodule
